FILE: src/awbg_pkg.sv
package awbg_pkg;

  localparam int unsigned FrameWidthDef  = 1920;
  localparam int unsigned FrameHeightDef = 1080;

  localparam int unsigned PixW   = 8;
  localparam int unsigned QuadW  = 10;
  localparam int unsigned RoiW   = 11;
  localparam int unsigned GainW  = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RedW   = 27;
  localparam int unsigned GreenW = 28;
  localparam int unsigned BlueW  = 27;

  localparam logic [PixW-1:0]  PixelLow  = 8'd0;
  localparam logic [PixW-1:0]  PixelHigh = 8'd255;
  localparam logic [GainW-1:0] GainMax   = 13'd4096;

  localparam logic [RoiW-1:0]  RoiLeftRst   = 11'd0;
  localparam logic [RoiW-1:0]  RoiTopRst    = 11'd0;
  localparam logic [RoiW-1:0]  RoiRightRst  = 11'd1920;
  localparam logic [RoiW-1:0]  RoiBottomRst = 11'd1080;
  localparam logic [GainW-1:0] RedGainRst   = 13'd566;
  localparam logic [GainW-1:0] GreenGainRst = 13'd256;
  localparam logic [GainW-1:0] BlueGainRst  = 13'd510;

  localparam logic [CfgIdxW-1:0] RegRoiLeft   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRoiTop    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRoiRight  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRoiBottom = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRedGain   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegGreenGain = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBlueGain  = 3'd6;

  typedef struct packed {
    logic [RoiW-1:0] left;
    logic [RoiW-1:0] top;
    logic [RoiW-1:0] right;
    logic [RoiW-1:0] bottom;
  } roi_cfg_t;

  typedef struct packed {
    logic acc;
    logic clr;
  } acc_ctrl_t;

endpackage

FILE: src/awbg_acc.sv
module awbg_acc
  import awbg_pkg::*;
#(
  parameter int unsigned FRAME_WIDTH  = FrameWidthDef,
  parameter int unsigned FRAME_HEIGHT = FrameHeightDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acc_ctrl_t         ctrl_i,
  input  roi_cfg_t          roi_i,
  input  logic [PixW-1:0]   red_i,
  input  logic [PixW-1:0]   green_row_i,
  input  logic [PixW-1:0]   green_col_i,
  input  logic [PixW-1:0]   blue_i,
  input  logic [QuadW-1:0]  quad_col_i,
  input  logic [QuadW-1:0]  quad_row_i,
  output logic [RedW-1:0]   red_total_o,
  output logic [GreenW-1:0] green_total_o,
  output logic [BlueW-1:0]  blue_total_o
);

  logic [RedW-1:0]   red_total_q, red_total_d;
  logic [GreenW-1:0] green_total_q, green_total_d;
  logic [BlueW-1:0]  blue_total_q, blue_total_d;

  logic [12:0]   px, py, x0, y0, x1, y1;
  logic          in_frame, in_roi, usable;
  logic [RedW:0]   red_add;
  logic [GreenW:0] green_add;
  logic [BlueW:0]  blue_add;

  always_comb begin
    px = {2'b0, quad_col_i, 1'b0};
    py = {2'b0, quad_row_i, 1'b0};
    x0 = {2'b0, roi_i.left[RoiW-1:1], 1'b0};
    y0 = {2'b0, roi_i.top[RoiW-1:1], 1'b0};
    x1 = {2'b0, roi_i.right} + {12'b0, roi_i.right[0]};
    y1 = {2'b0, roi_i.bottom} + {12'b0, roi_i.bottom[0]};
    in_frame = (px + 13'd2 <= 13'(FRAME_WIDTH)) && (py + 13'd2 <= 13'(FRAME_HEIGHT));
    in_roi = (px >= x0) && (px < x1) && (py >= y0) && (py < y1);
    usable = (green_row_i != PixelLow) && (green_row_i != PixelHigh);

    red_add   = {1'b0, red_total_q} + (RedW+1)'(red_i);
    green_add = {1'b0, green_total_q} + (GreenW+1)'(green_row_i)
              + (GreenW+1)'(green_col_i);
    blue_add  = {1'b0, blue_total_q} + (BlueW+1)'(blue_i);

    red_total_d   = red_total_q;
    green_total_d = green_total_q;
    blue_total_d  = blue_total_q;
    priority if (ctrl_i.clr) begin
      red_total_d   = '0;
      green_total_d = '0;
      blue_total_d  = '0;
    end else if (ctrl_i.acc && in_frame && in_roi && usable) begin
      red_total_d   = red_add[RedW] ? '1 : red_add[RedW-1:0];
      green_total_d = green_add[GreenW] ? '1 : green_add[GreenW-1:0];
      blue_total_d  = blue_add[BlueW] ? '1 : blue_add[BlueW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_total_q   <= '0;
      green_total_q <= '0;
      blue_total_q  <= '0;
    end else begin
      red_total_q   <= red_total_d;
      green_total_q <= green_total_d;
      blue_total_q  <= blue_total_d;
    end
  end

  assign red_total_o   = red_total_q;
  assign green_total_o = green_total_q;
  assign blue_total_o  = blue_total_q;

endmodule

FILE: src/gray_world_awb_gain_top.sv
// Gray-world white balance gain computer for an RGGB Bayer quad stream.
// Input channel: one quad per transfer (four samples, quad column/row and
// end_of_frame) on in_valid_i / in_stall_o. Quads that lie in the frame and
// in the even-aligned ROI and whose row green is not 0 or 255 are summed.
// Ordinary quads are taken one per cycle.
// A quad with end_of_frame set is summed, then the block stalls its input
// while one shared 27x13 multiplier and a restoring divider work out the
// red gain and then the blue gain: per gain a numerator multiply, a
// denominator multiply, 14 divide steps and a wrap-up step; S_OUT then
// loads the result register once it is free, and the next quad is taken
// in the cycle after that load.
// Output channel: one transfer per frame on out_valid_o / out_stall_i,
// carrying both Q8 gains (clamped to 4096) and the clamp flag. A held
// result stays in the output register while the input keeps streaming;
// a second result waits until the first has been taken.
// Sums clear when the result is loaded. Reset clears the sums, the output
// register and restores the default ROI and gains. Configuration writes
// through cfg_we_i/cfg_idx_i/cfg_data_i take effect on the next cycle.
module gray_world_awb_gain_top
  import awbg_pkg::*;
#(
  parameter int unsigned FRAME_WIDTH  = FrameWidthDef,
  parameter int unsigned FRAME_HEIGHT = FrameHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [GainW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PixW-1:0]    red_sample_i,
  input  logic [PixW-1:0]    green_row_sample_i,
  input  logic [PixW-1:0]    green_col_sample_i,
  input  logic [PixW-1:0]    blue_sample_i,
  input  logic [QuadW-1:0]   quad_col_i,
  input  logic [QuadW-1:0]   quad_row_i,
  input  logic               end_of_frame_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [GainW-1:0]   new_red_gain_o,
  output logic [GainW-1:0]   new_blue_gain_o,
  output logic               clamped_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MULN, S_MULD, S_DIV, S_NEXT, S_OUT
  } state_e;

  localparam int unsigned QW   = 14;
  localparam int unsigned RemW = 48;
  localparam int unsigned DvsW = 53;
  localparam int unsigned MulW = 40;

  state_e state_q;
  logic   chan_q;
  logic [3:0] cnt_q;
  logic [RemW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [QW-1:0]   quo_q;
  logic            dz_q;
  logic [GainW-1:0] red_res_q;
  logic             red_flag_q;

  logic             out_valid_q, clamped_q;
  logic [GainW-1:0] new_red_q, new_blue_q;

  roi_cfg_t         roi_q;
  logic [GainW-1:0] red_gain_q, green_gain_q, blue_gain_q;

  logic [RedW-1:0]   red_total;
  logic [GreenW-1:0] green_total;
  logic [BlueW-1:0]  blue_total;
  acc_ctrl_t         acc_ctrl;

  logic              in_xfer, out_free;
  logic [RedW-1:0]   mul_a;
  logic [GainW-1:0]  mul_b;
  logic [MulW-1:0]   mul_p;
  logic [DvsW-1:0]   rem_ext;
  logic              step_ge;
  logic              res_flag;
  logic [GainW-1:0]  res_gain;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign acc_ctrl.acc = in_xfer;
  assign acc_ctrl.clr = (state_q == S_OUT) && out_free;

  // shared multiplier: numerator half_green*gain, then colour*green_gain
  always_comb begin
    if (state_q == S_MULN) begin
      mul_a = green_total[GreenW-1:1];
      mul_b = chan_q ? blue_gain_q : red_gain_q;
    end else begin
      mul_a = chan_q ? blue_total : red_total;
      mul_b = green_gain_q;
    end
    mul_p = MulW'(mul_a) * MulW'(mul_b);
  end

  assign rem_ext  = DvsW'(rem_q);
  assign step_ge  = rem_ext >= dvs_q;
  assign res_flag = dz_q || (quo_q > QW'(GainMax));
  assign res_gain = res_flag ? GainMax : quo_q[GainW-1:0];

  awbg_acc #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (acc_ctrl),
    .roi_i        (roi_q),
    .red_i        (red_sample_i),
    .green_row_i  (green_row_sample_i),
    .green_col_i  (green_col_sample_i),
    .blue_i       (blue_sample_i),
    .quad_col_i   (quad_col_i),
    .quad_row_i   (quad_row_i),
    .red_total_o  (red_total),
    .green_total_o(green_total),
    .blue_total_o (blue_total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_q.left   <= RoiLeftRst;
      roi_q.top    <= RoiTopRst;
      roi_q.right  <= RoiRightRst;
      roi_q.bottom <= RoiBottomRst;
      red_gain_q   <= RedGainRst;
      green_gain_q <= GreenGainRst;
      blue_gain_q  <= BlueGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRoiLeft:   roi_q.left   <= cfg_data_i[RoiW-1:0];
        RegRoiTop:    roi_q.top    <= cfg_data_i[RoiW-1:0];
        RegRoiRight:  roi_q.right  <= cfg_data_i[RoiW-1:0];
        RegRoiBottom: roi_q.bottom <= cfg_data_i[RoiW-1:0];
        RegRedGain:   red_gain_q   <= cfg_data_i;
        RegGreenGain: green_gain_q <= cfg_data_i;
        RegBlueGain:  blue_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chan_q      <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      dvs_q       <= '0;
      quo_q       <= '0;
      dz_q        <= 1'b0;
      red_res_q   <= '0;
      red_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
      clamped_q   <= 1'b0;
      new_red_q   <= '0;
      new_blue_q  <= '0;
    end else begin
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer && end_of_frame_i) begin
            chan_q  <= 1'b0;
            state_q <= S_MULN;
          end
        end
        S_MULN: begin
          rem_q   <= {mul_p, 8'b0};
          state_q <= S_MULD;
        end
        S_MULD: begin
          dvs_q   <= {mul_p, 13'b0};
          dz_q    <= (mul_p == '0);
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (step_ge) begin
            rem_q <= RemW'(rem_ext - dvs_q);
          end
          quo_q <= {quo_q[QW-2:0], step_ge};
          dvs_q <= dvs_q >> 1;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(QW - 1)) begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (!chan_q) begin
            red_res_q  <= res_gain;
            red_flag_q <= res_flag;
            chan_q     <= 1'b1;
            state_q    <= S_MULN;
          end else begin
            state_q    <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            new_blue_q <= res_gain;
            clamped_q  <= res_flag || red_flag_q;
            new_red_q  <= red_res_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign new_red_gain_o  = new_red_q;
  assign new_blue_gain_o = new_blue_q;
  assign clamped_o       = clamped_q;

`ifndef SYNTHESIS
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (new_red_gain_o <= GainMax) && (new_blue_gain_o <= GainMax))
    else $error("gain above limit");
  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamped_o |-> (new_red_gain_o == GainMax) || (new_blue_gain_o == GainMax))
    else $error("clamp flag without clamped gain");
  a_eof_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && end_of_frame_i |=> in_stall_o)
    else $error("end of frame did not start the gain sequence");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q < 4'(QW))
    else $error("divide step count overrun");
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_ctrl.clr |=> !in_stall_o && out_valid_o)
    else $error("sum clear without result load");
`endif

endmodule

FILE: tb/gray_world_awb_gain_top_test.sv
module gray_world_awb_gain_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import awbg_pkg::*;

  typedef struct packed {
    logic [PixW-1:0]  red;
    logic [PixW-1:0]  green_row;
    logic [PixW-1:0]  green_col;
    logic [PixW-1:0]  blue;
    logic [QuadW-1:0] col;
    logic [QuadW-1:0] row;
    logic             eof;
  } quad_t;

  typedef struct packed {
    logic [GainW-1:0] red;
    logic [GainW-1:0] blue;
    logic             clamped;
  } gain_pair_t;

  typedef enum int {
    CfgReset, CfgOddRoi, CfgWide, CfgInverted, CfgEmpty, CfgZeroGain, CfgCorner, CfgRandom
  } roi_gain_set_e;

  localparam logic [CfgIdxW-1:0] RegNone = 3'd7;
  localparam longint unsigned Q8One       = 256;
  localparam longint unsigned RedAccMax   = (64'd1 << RedW) - 1;
  localparam longint unsigned GreenAccMax = (64'd1 << GreenW) - 1;
  localparam longint unsigned BlueAccMax  = (64'd1 << BlueW) - 1;
  localparam int unsigned QuadMax      = (1 << QuadW) - 1;
  localparam int unsigned SettleCycles = 48;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned PhaseQuads   = 100;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [GainW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [PixW-1:0]    red_sample_i = '0;
  logic [PixW-1:0]    green_row_sample_i = '0;
  logic [PixW-1:0]    green_col_sample_i = '0;
  logic [PixW-1:0]    blue_sample_i = '0;
  logic [QuadW-1:0]   quad_col_i = '0;
  logic [QuadW-1:0]   quad_row_i = '0;
  logic               end_of_frame_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [GainW-1:0]   new_red_gain_o;
  logic [GainW-1:0]   new_blue_gain_o;
  logic               clamped_o;

  // register copies as the block should hold them
  logic [RoiW-1:0]  left_px   = RoiLeftRst;
  logic [RoiW-1:0]  top_px    = RoiTopRst;
  logic [RoiW-1:0]  right_px  = RoiRightRst;
  logic [RoiW-1:0]  bottom_px = RoiBottomRst;
  logic [GainW-1:0] red_q8    = RedGainRst;
  logic [GainW-1:0] green_q8  = GreenGainRst;
  logic [GainW-1:0] blue_q8   = BlueGainRst;

  longint unsigned red_acc = 0;
  longint unsigned green_acc = 0;
  longint unsigned blue_acc = 0;

  quad_t      quad_backlog_q[$];
  gain_pair_t gains_due_q[$];

  quad_t          quad_on_bus;
  int unsigned    px, py, x1, y1;
  logic [GainW:0] red_fit, blue_fit;
  gain_pair_t     due;
  gain_pair_t     front;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quads_taken = 0;
  int unsigned clamps_due = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  gray_world_awb_gain_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .red_sample_i,
    .green_row_sample_i,
    .green_col_sample_i,
    .blue_sample_i,
    .quad_col_i,
    .quad_row_i,
    .end_of_frame_i,
    .out_valid_o,
    .out_stall_i,
    .new_red_gain_o,
    .new_blue_gain_o,
    .clamped_o
  );

  always #5 clk_i = ~clk_i;

  // {clamped, gain} = floor(256 * half_green * gain / (colour * green_gain))
  function automatic logic [GainW:0] q8_gain(longint unsigned half_green,
                                             longint unsigned colour,
                                             longint unsigned gain,
                                             longint unsigned g_gain);
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    den = colour * g_gain;
    num = Q8One * half_green * gain;
    if (den == 0) return {1'b1, GainMax};
    quo = num / den;
    if (quo > GainMax) return {1'b1, GainMax};
    return {1'b0, quo[GainW-1:0]};
  endfunction

  // half the time near the ROI span (always anywhere if the span is empty), otherwise anywhere in the field range
  function automatic logic [QuadW-1:0] pick_coord(logic [RoiW-1:0] lo_px,
                                                  logic [RoiW-1:0] hi_px);
    int unsigned lo;
    int unsigned hi;
    lo = lo_px / 2;
    hi = (hi_px + 1) / 2;
    if (hi <= lo || $urandom_range(1) == 0) return QuadW'($urandom_range(QuadMax));
    lo = (lo > 2) ? lo - 2 : 0;
    hi = (hi + 1 > QuadMax) ? QuadMax : hi + 1;
    return QuadW'($urandom_range(hi, lo));
  endfunction

  task automatic push_quad(logic [PixW-1:0] r, logic [PixW-1:0] gr, logic [PixW-1:0] gc,
                           logic [PixW-1:0] b, logic [QuadW-1:0] col,
                           logic [QuadW-1:0] row, logic eof);
    quad_t q;
    q = '{r, gr, gc, b, col, row, eof};
    quad_backlog_q.push_back(q);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      RegRoiLeft:   left_px = data[RoiW-1:0];
      RegRoiTop:    top_px = data[RoiW-1:0];
      RegRoiRight:  right_px = data[RoiW-1:0];
      RegRoiBottom: bottom_px = data[RoiW-1:0];
      RegRedGain:   red_q8 = data;
      RegGreenGain: green_q8 = data;
      RegBlueGain:  blue_q8 = data;
      default: ;
    endcase
  endtask

  task automatic write_roi(logic [GainW-1:0] l, logic [GainW-1:0] t,
                           logic [GainW-1:0] r, logic [GainW-1:0] b);
    write_reg(RegRoiLeft, l);
    write_reg(RegRoiTop, t);
    write_reg(RegRoiRight, r);
    write_reg(RegRoiBottom, b);
  endtask

  task automatic write_gains(logic [GainW-1:0] r, logic [GainW-1:0] g, logic [GainW-1:0] b);
    write_reg(RegRedGain, r);
    write_reg(RegGreenGain, g);
    write_reg(RegBlueGain, b);
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for the stream to empty and the due results to arrive, then let the block settle
  task automatic drain_all();
    int unsigned guard;
    guard = 0;
    while ((quad_backlog_q.size() != 0 || in_valid_i || gains_due_q.size() != 0) &&
           guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // quad driver and frame-sum tracking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        quads_taken++;
        px = {quad_on_bus.col, 1'b0};
        py = {quad_on_bus.row, 1'b0};
        x1 = right_px + right_px[0];
        y1 = bottom_px + bottom_px[0];
        if (px + 2 <= FrameWidthDef && py + 2 <= FrameHeightDef &&
            px >= {left_px[RoiW-1:1], 1'b0} && px < x1 &&
            py >= {top_px[RoiW-1:1], 1'b0} && py < y1 &&
            quad_on_bus.green_row != PixelLow && quad_on_bus.green_row != PixelHigh) begin
          red_acc = red_acc + quad_on_bus.red;
          green_acc = green_acc + quad_on_bus.green_row + quad_on_bus.green_col;
          blue_acc = blue_acc + quad_on_bus.blue;
          if (red_acc > RedAccMax) red_acc = RedAccMax;
          if (green_acc > GreenAccMax) green_acc = GreenAccMax;
          if (blue_acc > BlueAccMax) blue_acc = BlueAccMax;
        end
        if (quad_on_bus.eof) begin
          red_fit = q8_gain(green_acc >> 1, red_acc, red_q8, green_q8);
          blue_fit = q8_gain(green_acc >> 1, blue_acc, blue_q8, green_q8);
          due.red = red_fit[GainW-1:0];
          due.blue = blue_fit[GainW-1:0];
          due.clamped = red_fit[GainW] | blue_fit[GainW];
          if (due.clamped) clamps_due++;
          gains_due_q.push_back(due);
          red_acc = 0;
          green_acc = 0;
          blue_acc = 0;
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (quad_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          quad_on_bus = quad_backlog_q.pop_front();
          in_valid_i         <= 1'b1;
          red_sample_i       <= quad_on_bus.red;
          green_row_sample_i <= quad_on_bus.green_row;
          green_col_sample_i <= quad_on_bus.green_col;
          blue_sample_i      <= quad_on_bus.blue;
          quad_col_i         <= quad_on_bus.col;
          quad_row_i         <= quad_on_bus.row;
          end_of_frame_i     <= quad_on_bus.eof;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // gain result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (gains_due_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected gain transfer: red=%0d blue=%0d clamped=%0d",
                     new_red_gain_o, new_blue_gain_o, clamped_o);
          mismatches++;
        end else begin
          front = gains_due_q.pop_front();
          if (new_red_gain_o !== front.red || new_blue_gain_o !== front.blue ||
              clamped_o !== front.clamped) begin
            if (mismatches < 10)
              $display("gain result %0d: expected red=%0d blue=%0d clamped=%0d, got %0d %0d %0d",
                       results_checked, front.red, front.blue, front.clamped,
                       new_red_gain_o, new_blue_gain_o, clamped_o);
            mismatches++;
          end
          results_checked++;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    roi_gain_set_e plan [PhaseCount];
    int unsigned   made;
    int unsigned   len;
    int unsigned   g;
    int unsigned   a;
    int unsigned   b;
    plan = '{CfgReset, CfgOddRoi, CfgRandom, CfgWide, CfgInverted, CfgRandom,
             CfgZeroGain, CfgCorner, CfgEmpty, CfgOddRoi, CfgRandom, CfgReset};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: field extremes, frame edges, saturated greens
    push_quad(8'd255, 8'd254, 8'd255, 8'd255, 10'd0, 10'd0, 1'b0);
    push_quad(8'd0, 8'd1, 8'd0, 8'd0, 10'd959, 10'd539, 1'b0);
    push_quad(8'd128, PixelLow, 8'd128, 8'd128, 10'd5, 10'd5, 1'b0);
    push_quad(8'd128, PixelHigh, 8'd128, 8'd128, 10'd6, 10'd5, 1'b0);
    push_quad(8'd200, 8'd100, 8'd100, 8'd50, 10'd960, 10'd0, 1'b0);
    push_quad(8'd200, 8'd100, 8'd100, 8'd50, 10'd0, 10'd540, 1'b0);
    push_quad(8'd170, 8'd170, 8'd85, 8'd85, 10'd1023, 10'd1023, 1'b0);
    push_quad(8'd85, 8'd85, 8'd170, 8'd170, 10'd512, 10'd256, 1'b0);
    push_quad(8'd100, 8'd128, 8'd129, 8'd60, 10'd300, 10'd200, 1'b1);
    // nothing summed -> zero divisor
    push_quad(8'd90, PixelHigh, 8'd90, 8'd90, 10'd20, 10'd20, 1'b1);
    // tiny colour sums -> gain far over the clamp
    push_quad(8'd1, 8'd254, 8'd254, 8'd1, 10'd10, 10'd10, 1'b1);
    // no red, normal blue
    push_quad(8'd0, 8'd200, 8'd200, 8'd100, 10'd12, 10'd12, 1'b1);
    drain_all();

    write_reg(RegGreenGain, 13'd0);
    end_writes();
    push_quad(8'd50, 8'd60, 8'd70, 8'd80, 10'd30, 10'd30, 1'b0);
    push_quad(8'd51, 8'd61, 8'd71, 8'd81, 10'd31, 10'd30, 1'b1);
    drain_all();

    // odd corners round outward; unused high data bits are dropped
    write_roi(13'h1803, 13'd3, 13'd7, 13'd5);
    write_gains(13'd0, GreenGainRst, GainMax);
    end_writes();
    push_quad(8'd10, 8'd20, 8'd30, 8'd40, 10'd0, 10'd1, 1'b0);
    push_quad(8'd11, 8'd21, 8'd31, 8'd41, 10'd1, 10'd1, 1'b0);
    push_quad(8'd12, 8'd22, 8'd32, 8'd42, 10'd3, 10'd2, 1'b0);
    push_quad(8'd13, 8'd23, 8'd33, 8'd43, 10'd4, 10'd2, 1'b0);
    push_quad(8'd14, 8'd24, 8'd34, 8'd44, 10'd1, 10'd3, 1'b0);
    push_quad(8'd15, 8'd25, 8'd35, 8'd45, 10'd2, 10'd0, 1'b1);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain_all();
      case (plan[ph])
        CfgReset: begin
          write_roi(RoiLeftRst, RoiTopRst, RoiRightRst, RoiBottomRst);
          write_gains(RedGainRst, GreenGainRst, BlueGainRst);
        end
        CfgOddRoi: begin
          a = $urandom_range(400) * 2 + 1;
          b = $urandom_range(200) * 2 + 1;
          write_roi(GainW'(a), GainW'(b), GainW'(a + 2 * $urandom_range(150, 1)),
                    GainW'(b + 2 * $urandom_range(100, 1)));
          write_gains(RedGainRst, GreenGainRst, BlueGainRst);
        end
        CfgWide: begin
          write_roi(13'd0, 13'd0, 13'd2047, 13'd2047);
          write_gains(13'd8191, 13'd1, GainMax);
        end
        CfgInverted: begin
          write_roi(13'd1500, 13'd900, 13'd200, 13'd100);
          write_gains(GainW'($urandom_range(2048, 32)), GainW'($urandom_range(1024, 64)),
                      GainW'($urandom_range(2048, 32)));
        end
        CfgEmpty: begin
          write_roi(13'd800, 13'd400, 13'd800, 13'd600);
        end
        CfgZeroGain: begin
          write_roi(RoiLeftRst, RoiTopRst, RoiRightRst, RoiBottomRst);
          write_gains(13'd0, 13'd8191, GainMax);
        end
        CfgCorner: begin
          write_roi(13'd1917, 13'd1077, 13'd1920, 13'd1080);
          write_gains(RedGainRst, GreenGainRst, BlueGainRst);
        end
        default: begin
          a = $urandom_range(1600);
          b = $urandom_range(900);
          write_roi(GainW'(($urandom_range(3) << RoiW) | a),
                    GainW'(($urandom_range(3) << RoiW) | b),
                    GainW'(a + $urandom_range(500, 2)), GainW'(b + $urandom_range(300, 2)));
          write_gains(GainW'($urandom_range(2048, 32)), GainW'($urandom_range(1024, 64)),
                      GainW'($urandom_range(2048, 32)));
          write_reg(RegNone, GainW'($urandom_range(8191)));
        end
      endcase
      end_writes();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      made = 0;
      while (made < PhaseQuads) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(100, 40) : $urandom_range(30, 1);
        for (int i = 0; i < len; i++) begin
          g = $urandom_range(19);
          push_quad(PixW'($urandom_range(255)),
                    (g == 0) ? PixelLow : (g == 1) ? PixelHigh : PixW'($urandom_range(255)),
                    PixW'($urandom_range(255)), PixW'($urandom_range(255)),
                    pick_coord(left_px, right_px), pick_coord(top_px, bottom_px),
                    i == len - 1);
        end
        made += len;
      end
    end
    drain_all();

    if (gains_due_q.size() != 0) begin
      $display("%0d gain results never arrived", gains_due_q.size());
      mismatches += gains_due_q.size();
    end
    $display("%0d quad transfers, %0d gain results checked (%0d clamped), %0d mismatches",
             quads_taken, results_checked, clamps_due, mismatches);
    $display("ROI and gain settings: reset, odd, wide, inverted, empty, zero, corner, random");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
